>>> rtl/dflux_pkg.sv
package dflux_pkg;

  // Number of dry-threshold registers held by the block.
  localparam int DRY_REGS = 5;

  // Wetness limits in Q1.15: one half, and the floor of 0.001.
  localparam logic [15:0] WET_LIMIT = 16'd16384;
  localparam logic [15:0] WET_FLOOR = 16'd33;

  // Moisture factor: 1.2 in Q.16 and 0.2*log10(2) in Q0.20.
  localparam logic [16:0] F_BASE  = 17'd78643;
  localparam logic [15:0] F_SLOPE = 16'd63131;

  // Lake fraction of one in Q1.15.
  localparam logic [15:0] LAKE_ONE = 16'd32768;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GAIN      = 3'd0;
  localparam logic [2:0] CFG_BIN_COUNT = 3'd1;
  localparam logic [2:0] CFG_DRY0      = 3'd2;
  localparam logic [2:0] CFG_DRY4      = 3'd6;

  typedef logic [15:0] dry_arr_t [DRY_REGS];

  // One prepared cell, handed from the front end to the bin engine.
  typedef struct packed {
    logic [15:0] w;      // wind speed, Q8.8
    logic [31:0] sq;     // squared wind speed, Q16.16
    logic [16:0] f;      // moisture factor, Q.16
    logic        land;
    logic [15:0] lakef;  // one minus lake fraction, Q1.15
    logic [47:0] g;      // gain times source strength
  } item_t;

endpackage

>>> rtl/dflux_front.sv
module dflux_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   wind_east,
  input  logic signed [15:0]   wind_north,
  input  logic [15:0]          soil_wetness,
  input  logic [1:0]           land_class,
  input  logic [15:0]          lake_cover,
  input  logic [15:0]          source_strength,
  input  logic [31:0]          gain,
  output logic                 push,
  input  logic                 q_ready,
  output dflux_pkg::item_t     item
);
  import dflux_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ITER   = 4'b0100,
    ST_FIN    = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] mag_e_r, mag_n_r, wet_r, lakef_r;
  logic        land_r;
  logic [47:0] g_r;
  logic [31:0] x_r, res_r, sq_r;
  logic [30:0] bit_r, m_r;
  logic [3:0]  p_r;
  logic [15:0] frac_r;

  logic        acc;
  logic [15:0] mag_e, mag_n, wc;
  logic [3:0]  p_c;
  logic [31:0] t_c;
  logic [61:0] sqm;
  logic [31:0] s_c;
  logic [19:0] nl;
  logic [35:0] dprod;
  logic [15:0] dec;
  logic [16:0] f_c;

  assign mag_e = wind_east[15] ? 16'(17'h10000 - {1'b0, wind_east}) : wind_east;
  assign mag_n = wind_north[15] ? 16'(17'h10000 - {1'b0, wind_north}) : wind_north;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_FIN) && q_ready);
  assign acc = in_valid && in_ready;
  assign push = (state_r == ST_FIN);

  // Leading one of the floored wetness.
  assign wc = (wet_r < WET_FLOOR) ? WET_FLOOR : wet_r;
  always_comb begin
    p_c = '0;
    for (int i = 0; i < 14; i++) begin
      if (wc[i]) p_c = 4'(i);
    end
  end

  // One square-root digit and one log bit per iteration.
  assign t_c = res_r + {1'b0, bit_r};
  assign sqm = m_r * m_r;
  assign s_c = sqm[61:30];

  // Moisture factor from minus log2 of the wetness.
  assign nl = {4'(4'd15 - p_r), 16'd0} - {4'd0, frac_r};
  assign dprod = F_SLOPE * nl;
  assign dec = dprod[35:20];
  always_comb begin
    if (wet_r >= WET_LIMIT || {1'b0, dec} >= F_BASE) begin
      f_c = '0;
    end else begin
      f_c = F_BASE - {1'b0, dec};
    end
  end

  always_comb begin
    item.w = res_r[15:0];
    item.sq = sq_r;
    item.f = f_c;
    item.land = land_r;
    item.lakef = lakef_r;
    item.g = g_r;
  end

  // Sequencing of the front end.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        state_nxt = ST_ITER;
        cnt_nxt = '0;
      end
      ST_ITER: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (acc) state_nxt = ST_SQUARE;
        else if (q_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      mag_e_r <= mag_e;
      mag_n_r <= mag_n;
      wet_r <= soil_wetness;
      land_r <= (land_class == 2'd1);
      lakef_r <= (lake_cover >= LAKE_ONE) ? 16'd0 : 16'(LAKE_ONE - lake_cover);
      g_r <= gain * source_strength;
    end
    if (state_r == ST_SQUARE) begin
      sq_r <= 32'(mag_e_r * mag_e_r) + 32'(mag_n_r * mag_n_r);
      x_r <= 32'(mag_e_r * mag_e_r) + 32'(mag_n_r * mag_n_r);
      res_r <= '0;
      bit_r <= 31'h4000_0000;
      p_r <= p_c;
      m_r <= 31'({15'd0, wc} << (5'd30 - {1'b0, p_c}));
      frac_r <= '0;
    end
    if (state_r == ST_ITER) begin
      if (x_r >= t_c) begin
        x_r <= x_r - t_c;
        res_r <= (res_r >> 1) + {1'b0, bit_r};
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      if (s_c[31]) begin
        m_r <= s_c[31:1];
        frac_r <= {frac_r[14:0], 1'b1};
      end else begin
        m_r <= s_c[30:0];
        frac_r <= {frac_r[14:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/dflux_queue.sv
module dflux_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             q_ready,
  input  dflux_pkg::item_t din,
  output logic             q_valid,
  input  logic             pop,
  output dflux_pkg::item_t dout
);
  import dflux_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign dout = mem_r[rp_r];
  assign do_push = push && q_ready;
  assign do_pop = pop && q_valid;

  // Two-entry queue between the front end and the bin engine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

>>> rtl/dflux_back.sv
module dflux_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               pop,
  input  dflux_pkg::item_t   item,
  input  logic [2:0]         nb,
  input  dflux_pkg::dry_arr_t dry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_bin_index,
  output logic [47:0]        out_emission,
  output logic               out_written,
  output logic               out_last_bin
);
  import dflux_pkg::*;

  logic        en;
  logic [2:0]  idx_r;
  logic        last_c;
  logic [15:0] dry_sel;

  logic [5:1]  v_r;
  logic [2:0]  bin_r [5:1];
  logic [5:1]  last_r;
  logic [5:2]  ok_r;
  logic [47:0] g_r [3:1];
  logic [15:0] w1_r;
  logic [31:0] sq1_r, sq2_r;
  logic        land1_r;
  logic [15:0] lakef1_r;
  logic [32:0] ut1_r;
  logic [31:0] a2_r;
  logic [63:0] y3_r;
  logic [63:0] pll4_r, plh4_r;
  logic [47:0] phl4_r, phh4_r;
  logic [63:0] pll5_r;
  logic [64:0] mid5_r;
  logic [47:0] phh5_r;

  logic [16:0]  ut;
  logic         ok2;
  logic [111:0] total;
  logic         out_valid_r, out_written_r, out_last_r;
  logic [2:0]   out_bin_r;
  logic [47:0]  out_em_r;

  assign en = !out_valid_r || out_ready;
  assign last_c = (idx_r == nb - 3'd1);
  assign pop = en && q_valid && ((nb == 3'd0) || last_c);
  assign dry_sel = (idx_r < 3'(DRY_REGS)) ? dry[idx_r] : 16'd0;

  // Bin sequencer: one bin of the head cell per cycle while the output is not stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (en && q_valid && nb != 3'd0) begin
      idx_r <= last_c ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[4:1], q_valid && nb != 3'd0};
      out_valid_r <= v_r[5];
    end
  end

  assign ut = ut1_r[32:16];
  assign ok2 = land1_r && (ut != 17'd0) && ({1'b0, w1_r} > ut);
  assign total = {48'd0, pll5_r} + {15'd0, mid5_r, 32'd0} + {phh5_r, 64'd0};

  // Pipeline: threshold, lake factor, wind cube, partial products, sum, saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      bin_r[1] <= idx_r;
      last_r[1] <= last_c;
      g_r[1] <= item.g;
      w1_r <= item.w;
      sq1_r <= item.sq;
      land1_r <= item.land;
      lakef1_r <= item.lakef;
      ut1_r <= dry_sel * item.f;

      bin_r[2] <= bin_r[1];
      last_r[2] <= last_r[1];
      g_r[2] <= g_r[1];
      sq2_r <= sq1_r;
      ok_r[2] <= ok2;
      a2_r <= lakef1_r * (w1_r - ut[15:0]);

      bin_r[3] <= bin_r[2];
      last_r[3] <= last_r[2];
      g_r[3] <= g_r[2];
      ok_r[3] <= ok_r[2];
      y3_r <= a2_r * sq2_r;

      bin_r[4] <= bin_r[3];
      last_r[4] <= last_r[3];
      ok_r[4] <= ok_r[3];
      pll4_r <= g_r[3][31:0] * y3_r[31:0];
      plh4_r <= g_r[3][31:0] * y3_r[63:32];
      phl4_r <= g_r[3][47:32] * y3_r[31:0];
      phh4_r <= g_r[3][47:32] * y3_r[63:32];

      bin_r[5] <= bin_r[4];
      last_r[5] <= last_r[4];
      ok_r[5] <= ok_r[4];
      pll5_r <= pll4_r;
      mid5_r <= {1'b0, plh4_r} + {17'd0, phl4_r};
      phh5_r <= phh4_r;

      out_bin_r <= bin_r[5];
      out_last_r <= last_r[5];
      out_written_r <= ok_r[5];
      if (!ok_r[5]) begin
        out_em_r <= '0;
      end else if (|total[111:78]) begin
        out_em_r <= '1;
      end else begin
        out_em_r <= total[77:30];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_bin_index = out_bin_r;
  assign out_emission = out_em_r;
  assign out_written = out_written_r;
  assign out_last_bin = out_last_r;

endmodule

>>> rtl/dust_emission_flux.sv
// Dust emission flux for one grid cell per input transfer, one result transfer per
// size bin in bin order. In the front end a 16-step bit-serial square root for wind
// speed runs beside a 16-step log2 by repeated squaring, and a new cell is taken only
// once the last one is finished and handed on. A two-entry queue feeds the bin engine,
// which issues one bin per cycle, unless the output stalls, into a six-stage multiply
// pipeline, so results stream at one per cycle. Configuration is written through the
// cfg_ port, always ready, only while idle: a rule for the user, not enforced by the block.
module dust_emission_flux #(
  parameter int MAX_BINS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_wind_east,
  input  logic signed [15:0]  in_wind_north,
  input  logic [15:0]         in_soil_wetness,
  input  logic [1:0]          in_land_class,
  input  logic [15:0]         in_lake_cover,
  input  logic [15:0]         in_source_strength,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_bin_index,
  output logic [47:0]         out_emission,
  output logic                out_written,
  output logic                out_last_bin,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import dflux_pkg::*;

  logic [31:0] gain_r;
  logic [2:0]  bin_count_r;
  dry_arr_t    dry_r;
  logic [2:0]  nb;
  logic        push, q_ready, q_valid, pop;
  item_t       f_item, q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      bin_count_r <= 3'd5;
      for (int i = 0; i < DRY_REGS; i++) dry_r[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_GAIN) gain_r <= cfg_data;
      else if (cfg_index == CFG_BIN_COUNT) bin_count_r <= cfg_data[2:0];
      else if (cfg_index >= CFG_DRY0 && cfg_index <= CFG_DRY4) begin
        dry_r[3'(cfg_index - CFG_DRY0)] <= cfg_data[15:0];
      end
    end
  end

  // Bins in use, limited to the bin capacity.
  assign nb = ({1'b0, bin_count_r} > 4'(MAX_BINS)) ? 3'(MAX_BINS) : bin_count_r;

  dflux_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .wind_east(in_wind_east), .wind_north(in_wind_north),
    .soil_wetness(in_soil_wetness), .land_class(in_land_class),
    .lake_cover(in_lake_cover), .source_strength(in_source_strength),
    .gain(gain_r), .push(push), .q_ready(q_ready), .item(f_item)
  );

  dflux_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .q_ready(q_ready), .din(f_item),
    .q_valid(q_valid), .pop(pop), .dout(q_item)
  );

  dflux_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .pop(pop), .item(q_item),
    .nb(nb), .dry(dry_r), .out_valid(out_valid), .out_ready(out_ready),
    .out_bin_index(out_bin_index), .out_emission(out_emission),
    .out_written(out_written), .out_last_bin(out_last_bin)
  );

endmodule
